// ===== rtl/core/doae_pkg.sv =====
package doae_pkg;

	localparam int ARC_IN_WIDTH = 64;
	localparam int BYTE_WIDTH   = 8;
	localparam int GROUP_BITS   = 7;
	localparam int FIRST_MUL    = 40;

	localparam logic [GROUP_BITS-1:0] GROUP_MASK = 7'h7F;
	localparam logic [BYTE_WIDTH-1:0] CONT_BIT   = 8'h80;

	typedef enum logic [1:0] {
		PHASE_NONE  = 2'd0,
		PHASE_FIRST = 2'd1,
		PHASE_BODY  = 2'd2
	} phase_t;

endpackage

// ===== rtl/core/doae_arc_if.sv =====
interface doae_arc_if import doae_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [ARC_IN_WIDTH-1:0] arc_value;
	logic                    first_arc;

	modport source (output valid, output arc_value, output first_arc, input ready);
	modport sink   (input valid, input arc_value, input first_arc, output ready);
endinterface

// ===== rtl/core/doae_byte_if.sv =====
interface doae_byte_if import doae_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [BYTE_WIDTH-1:0] out_byte;
	logic                  last_byte;
	logic                  error_flag;

	modport source (output valid, output out_byte, output last_byte, output error_flag,
		input ready);
	modport sink   (input valid, input out_byte, input last_byte, input error_flag,
		output ready);
endinterface

// ===== rtl/core/der_oid_arc_encoder_core.sv =====
// DER object identifier arc encoder: takes one numeric arc per transfer on arc_in and
// gives the base-128 content bytes on byte_out, most significant group first, bit 7 set
// on all but the last byte of an arc. The arc marked first_arc is held and gives no byte;
// the next arc is merged as first*40+second, and a merge that does not fit in ARC_WIDTH
// bits, an arc with no identifier open, or a new identifier after a single arc gives one
// error byte instead. One arc is in work at a time and arc_in is not ready meanwhile.
// A held first arc is only accepted; an error passes accept and error byte, and when the
// merge overflows it passes accept, two adder passes and error byte; a later arc passes
// accept, group search, then one byte per cycle while byte_out is ready; the second arc
// also runs the merge twice through the one shared adder (x*32 + x*8, then + second arc).
// An output stall holds the byte on byte_out until it is taken.
module der_oid_arc_encoder_core import doae_pkg::*; #(
	parameter int ARC_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	doae_arc_if.sink    arc_in,
	doae_byte_if.source byte_out
);

	localparam int SUM_WIDTH = ARC_WIDTH + 6;
	localparam int NUM_GROUPS = (ARC_WIDTH + GROUP_BITS - 1) / GROUP_BITS;
	localparam int PAD_WIDTH = NUM_GROUPS * GROUP_BITS;
	localparam int IDX_WIDTH = $clog2(NUM_GROUPS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_ADD,
		S_GRP,
		S_EMIT,
		S_ERR
	} state_t;

	state_t                 state_q;
	phase_t                 phase_q;
	logic [ARC_WIDTH-1:0]   held_q;
	logic [ARC_WIDTH-1:0]   arc_q;
	logic [SUM_WIDTH-1:0]   acc_q;
	logic [ARC_WIDTH-1:0]   val_q;
	logic [IDX_WIDTH-1:0]   idx_q;

	logic [ARC_WIDTH-1:0]   arc_in_w;
	logic [SUM_WIDTH-1:0]   add_a;
	logic [SUM_WIDTH-1:0]   add_b;
	logic [SUM_WIDTH-1:0]   sum;
	logic [PAD_WIDTH-1:0]   val_pad;
	logic [IDX_WIDTH-1:0]   top_grp;
	logic [GROUP_BITS-1:0]  grp;

	assign arc_in_w = arc_in.arc_value[ARC_WIDTH-1:0];

	// shared adder: x*40 as two shifted copies, then the second arc
	always_comb begin
		if (state_q == S_MUL) begin
			add_a = SUM_WIDTH'({held_q, 5'b0});
			add_b = SUM_WIDTH'({held_q, 3'b0});
		end else begin
			add_a = acc_q;
			add_b = SUM_WIDTH'(arc_q);
		end
	end
	assign sum = add_a + add_b;

	assign val_pad = PAD_WIDTH'(val_q);

	// highest non-zero group, zero gives a single byte
	always_comb begin
		top_grp = '0;
		for (int i = 1; i < NUM_GROUPS; i++) begin
			if (val_pad[i*GROUP_BITS +: GROUP_BITS] != '0)
				top_grp = IDX_WIDTH'(i);
		end
	end

	assign grp = val_pad[idx_q*GROUP_BITS +: GROUP_BITS] & GROUP_MASK;

	assign arc_in.ready        = (state_q == S_IDLE);
	assign byte_out.valid      = (state_q == S_EMIT) || (state_q == S_ERR);
	assign byte_out.error_flag = (state_q == S_ERR);
	assign byte_out.last_byte  = (state_q == S_ERR) || (idx_q == '0);
	always_comb begin
		if (state_q == S_EMIT) begin
			byte_out.out_byte = BYTE_WIDTH'(grp);
			if (idx_q != '0)
				byte_out.out_byte = byte_out.out_byte | CONT_BIT;
		end else begin
			byte_out.out_byte = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PHASE_NONE;
			held_q  <= '0;
			arc_q   <= '0;
			acc_q   <= '0;
			val_q   <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (arc_in.valid) begin
						arc_q <= arc_in_w;
						val_q <= arc_in_w;
						if (arc_in.first_arc) begin
							held_q  <= arc_in_w;
							phase_q <= PHASE_FIRST;
							if (phase_q == PHASE_FIRST)
								state_q <= S_ERR;
						end else begin
							case (phase_q)
								PHASE_FIRST: state_q <= S_MUL;
								PHASE_BODY:  state_q <= S_GRP;
								default:     state_q <= S_ERR;
							endcase
						end
					end
				end
				S_MUL: begin
					acc_q   <= sum;
					state_q <= S_ADD;
				end
				S_ADD: begin
					if (sum[SUM_WIDTH-1:ARC_WIDTH] != '0) begin
						phase_q <= PHASE_NONE;
						state_q <= S_ERR;
					end else begin
						val_q   <= sum[ARC_WIDTH-1:0];
						phase_q <= PHASE_BODY;
						state_q <= S_GRP;
					end
				end
				S_GRP: begin
					idx_q   <= top_grp;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (byte_out.ready) begin
						if (idx_q == '0)
							state_q <= S_IDLE;
						else
							idx_q <= idx_q - 1'b1;
					end
				end
				S_ERR: begin
					if (byte_out.ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/doae_checker.sv =====
module doae_checker import doae_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [BYTE_WIDTH-1:0] out_byte,
	input logic                  last_byte,
	input logic                  error_flag
);

	// one arc in work at a time
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a byte is offered");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error_flag) |-> (out_byte == '0 && last_byte))
		else $error("error result not a single zero byte");

	a_cont_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !error_flag) |-> (out_byte[BYTE_WIDTH-1] == !last_byte))
		else $error("continuation bit does not match last byte");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_byte) |=> !out_valid)
		else $error("byte offered after last transfer of an arc");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_byte)))
		else $error("stalled byte changed");

endmodule

bind der_oid_arc_encoder_core doae_checker u_doae_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (arc_in.ready),
	.out_valid  (byte_out.valid),
	.out_ready  (byte_out.ready),
	.out_byte   (byte_out.out_byte),
	.last_byte  (byte_out.last_byte),
	.error_flag (byte_out.error_flag)
);
